/* rtl/strict_base64_stream_decoder_macros.svh */
// assertion macros for the strict base64 stream decoder
`ifndef STRICT_BASE64_STREAM_DECODER_MACROS_SVH
`define STRICT_BASE64_STREAM_DECODER_MACROS_SVH

// property checked on every rising clock edge, off while reset is asserted
`define B64D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication: a condition in one cycle requires a property in the next
`define B64D_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/b64d_pkg.sv */
// types, constants and symbol map for the strict base64 stream decoder
package b64d_pkg;

  // symbol codes: 0..63 data, then padding and illegal markers
  typedef logic [6:0] sym_t;
  localparam sym_t SymPad   = 7'd64;
  localparam sym_t SymBad   = 7'd127;
  localparam sym_t SymPlus  = 7'd62;
  localparam sym_t SymSlash = 7'd63;

  // output queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned MaxPush = 3;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StNoSpace = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } out_item_t;

  // map one character to its symbol value
  function automatic sym_t sym_value(input logic [7:0] c);
    sym_t s;
    s = SymBad;
    if (c >= 8'h41 && c <= 8'h5A) begin        // A..Z
      s = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin // a..z
      s = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin // 0..9
      s = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin             // plus
      s = SymPlus;
    end else if (c == 8'h2F) begin             // slash
      s = SymSlash;
    end else if (c == 8'h3D) begin             // equals
      s = SymPad;
    end
    return s;
  endfunction

  // space, tab, carriage return, line feed
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

endpackage

/* rtl/strict_base64_stream_decoder.sv */
// strict base64 stream decoder: character in, decoded bytes and status out
//
// Input channel (in_valid_i/in_ready_o) carries one text character per word,
// or an end-of-text word that closes the element. Blanks are skipped; every
// fourth symbol completes a group and yields up to three data words on the
// output channel (out_valid_o/out_ready_i). An end-of-text word yields one
// status word with last_o set and clears the group state, the error and the byte count.
// Results of an accepted word are registered into the queue behind the
// words already queued. One input word is taken per cycle while at most
// one result is queued; in_ready_o is low while more than one is queued,
// so a two- or three-byte group holds the input off until the queue has
// drained to one word. A group's bytes leave one per cycle, while the
// receiver is ready, through a four-entry queue. The capacity register
// must be written through cfg_we_i/cfg_wdata_i by the user only while
// idle; the block does not enforce it. It bounds the data bytes per
// element, after which no_space latches. Reset clears the queue, the group
// state and the error, and sets the capacity to 65535. When the receiver
// stalls, queued words hold; the input side backs off once two are queued.
module strict_base64_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_char_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  // stream state
  logic [15:0]             cap_q;
  b64d_pkg::sym_t          hold_q [3];
  b64d_pkg::sym_t          hold_d [3];
  logic [1:0]              sym_cnt_q, sym_cnt_d;
  logic                    pad_seen_q, pad_seen_d;
  b64d_pkg::status_e       err_q, err_d;
  logic [15:0]             bw_q, bw_d;

  // output queue
  b64d_pkg::out_item_t     q_q [b64d_pkg::QDepth];
  b64d_pkg::out_item_t     q_d [b64d_pkg::QDepth];
  b64d_pkg::out_item_t     q_sh [b64d_pkg::QDepth];
  logic [b64d_pkg::QCntW-1:0] cnt_q, cnt_d, base;

  // decode datapath
  b64d_pkg::out_item_t     push_item [b64d_pkg::MaxPush];
  logic [1:0]              n_push;
  logic                    in_acc, pop;
  b64d_pkg::sym_t          v, q0, q1, q2, q3;
  logic                    bad_pad;
  logic [1:0]              n_want, n_fit, n_emit;
  logic                    r1, r2, r3;
  b64d_pkg::status_e       end_st;

  assign in_ready_o  = (cnt_q <= b64d_pkg::QCntW'(1));
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;
  assign out_byte_o  = q_q[0].data;
  assign status_o    = q_q[0].status;
  assign last_o      = q_q[0].last;

  // group operands and byte assembly
  assign v  = b64d_pkg::sym_value(in_char_i);
  assign q0 = hold_q[0];
  assign q1 = hold_q[1];
  assign q2 = hold_q[2];
  assign q3 = v;

  assign bad_pad = (q0 == b64d_pkg::SymPad) || (q1 == b64d_pkg::SymPad) ||
                   (q2 == b64d_pkg::SymPad && q3 != b64d_pkg::SymPad) ||
                   (q2 == b64d_pkg::SymPad && q1[3:0] != 4'd0) ||
                   (q3 == b64d_pkg::SymPad && q2 != b64d_pkg::SymPad &&
                    q2[1:0] != 2'd0);

  // remaining capacity, up to one group's worth
  assign r1 = bw_q < cap_q;
  assign r2 = ({1'b0, bw_q} + 17'd1) < {1'b0, cap_q};
  assign r3 = ({1'b0, bw_q} + 17'd2) < {1'b0, cap_q};
  assign n_fit  = r3 ? 2'd3 : (r2 ? 2'd2 : (r1 ? 2'd1 : 2'd0));
  assign n_want = 2'd1 + {1'b0, q2 != b64d_pkg::SymPad} + {1'b0, q3 != b64d_pkg::SymPad};
  assign n_emit = (n_fit < n_want) ? n_fit : n_want;

  // final status of an element
  always_comb begin
    end_st = err_q;
    if (err_q == b64d_pkg::StOk && sym_cnt_q != 2'd0) begin
      end_st = b64d_pkg::StInvalid;
    end
  end

  // next stream state and words to queue
  always_comb begin
    hold_d     = hold_q;
    sym_cnt_d  = sym_cnt_q;
    pad_seen_d = pad_seen_q;
    err_d      = err_q;
    bw_d       = bw_q;
    n_push     = 2'd0;
    push_item[0] = '{data: {q0[5:0], q1[5:4]}, status: b64d_pkg::StOk, last: 1'b0};
    push_item[1] = '{data: {q1[3:0], q2[5:2]}, status: b64d_pkg::StOk, last: 1'b0};
    push_item[2] = '{data: {q2[1:0], q3[5:0]}, status: b64d_pkg::StOk, last: 1'b0};
    if (in_acc) begin
      if (end_of_text_i) begin
        push_item[0] = '{data: 8'd0, status: end_st, last: 1'b1};
        n_push     = 2'd1;
        hold_d[0]  = '0;
        hold_d[1]  = '0;
        hold_d[2]  = '0;
        sym_cnt_d  = 2'd0;
        pad_seen_d = 1'b0;
        err_d      = b64d_pkg::StOk;
        bw_d       = 16'd0;
      end else if (err_q != b64d_pkg::StOk || b64d_pkg::is_blank(in_char_i)) begin
        // ignored
      end else if (pad_seen_q || v == b64d_pkg::SymBad) begin
        err_d = b64d_pkg::StInvalid;
      end else if (sym_cnt_q != 2'd3) begin
        hold_d[sym_cnt_q] = v;
        sym_cnt_d = sym_cnt_q + 2'd1;
      end else begin
        sym_cnt_d = 2'd0;
        if (bad_pad) begin
          err_d = b64d_pkg::StInvalid;
        end else begin
          n_push = n_emit;
          bw_d   = bw_q + 16'(n_emit);
          if (n_emit < n_want) begin
            err_d = b64d_pkg::StNoSpace;
          end else begin
            pad_seen_d = (q3 == b64d_pkg::SymPad);
          end
        end
      end
    end
  end

  // output queue: shift on pop, append new words behind the survivors
  always_comb begin
    q_sh[0] = pop ? q_q[1] : q_q[0];
    q_sh[1] = pop ? q_q[2] : q_q[1];
    q_sh[2] = pop ? q_q[3] : q_q[2];
    q_sh[3] = q_q[3];
    base  = cnt_q - b64d_pkg::QCntW'(pop);
    cnt_d = base + b64d_pkg::QCntW'(n_push);
    for (int i = 0; i < b64d_pkg::QDepth; i++) begin
      q_d[i] = q_sh[i];
      if (b64d_pkg::QCntW'(i) >= base && b64d_pkg::QCntW'(i) < cnt_d) begin
        q_d[i] = push_item[2'(b64d_pkg::QCntW'(i) - base)];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= 16'hFFFF;
      sym_cnt_q  <= 2'd0;
      pad_seen_q <= 1'b0;
      err_q      <= b64d_pkg::StOk;
      bw_q       <= 16'd0;
      cnt_q      <= '0;
      hold_q[0]  <= '0;
      hold_q[1]  <= '0;
      hold_q[2]  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      sym_cnt_q  <= sym_cnt_d;
      pad_seen_q <= pad_seen_d;
      err_q      <= err_d;
      bw_q       <= bw_d;
      cnt_q      <= cnt_d;
      hold_q     <= hold_d;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

`include "strict_base64_stream_decoder_macros.svh"

  `B64D_ASSERT(a_queue_bound, cnt_q <= b64d_pkg::QCntW'(b64d_pkg::QDepth), "output queue overflow")
  `B64D_ASSERT(a_pad_no_partial, !pad_seen_q || sym_cnt_q == 2'd0, "symbols held after padded group")
  `B64D_ASSERT_NEXT(a_end_clears, in_acc && end_of_text_i, sym_cnt_q == 2'd0 && err_q == b64d_pkg::StOk && bw_q == 16'd0 && !pad_seen_q, "end word did not clear state")
  `B64D_ASSERT_NEXT(a_err_sticky, err_q != b64d_pkg::StOk && !(in_acc && end_of_text_i), err_q == $past(err_q), "latched error changed")

endmodule

/* dv/strict_base64_stream_decoder_tb.sv */
// self-checking testbench for the strict base64 stream decoder
module strict_base64_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 100000;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 4;
  localparam int PhaseWords  = 105;

  // ascii codes the stimulus needs by name
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChPad   = 8'h3D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChZero  = 8'h30;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = 16'd0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_char_i     = 8'd0;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  out_byte_o;
  logic [1:0]  status_o;
  logic        last_o;

  strict_base64_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_char_i     (in_char_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  text_word_t          word_q [$];
  b64d_pkg::out_item_t decoded_q [$];
  text_word_t          drv_word;
  b64d_pkg::out_item_t want;
  int         send_idle_pct = 18;
  int         recv_idle_pct = 47;
  int         cycle_cnt     = 0;
  int         mismatch_cnt  = 0;
  int         pushed_cnt    = 0;
  int         hold_left     = 0;
  logic       hold_req      = 1'b0;

  // decoder shadow state
  b64d_pkg::sym_t    grp_sym [3];
  int                grp_cnt   = 0;
  logic              after_pad = 1'b0;
  b64d_pkg::status_e err       = b64d_pkg::StOk;
  logic [15:0]       emitted   = 16'd0;
  logic [15:0]       cap       = 16'hFFFF;

  // clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("strict_base64_stream_decoder_tb: FAIL");
      $finish;
    end
  end

  function automatic logic is_space(input logic [7:0] ch);
    return ch == ChSpace || ch == ChTab || ch == ChCr || ch == ChLf;
  endfunction

  // character to 6-bit symbol, pad marker or illegal marker
  function automatic b64d_pkg::sym_t char_to_sym(input logic [7:0] ch);
    b64d_pkg::sym_t s;
    if (ch >= ChUpA && ch < ChUpA + 8'd26) s = b64d_pkg::sym_t'(ch - ChUpA);
    else if (ch >= ChLowA && ch < ChLowA + 8'd26)
      s = b64d_pkg::sym_t'(ch - ChLowA + 8'd26);
    else if (ch >= ChZero && ch < ChZero + 8'd10)
      s = b64d_pkg::sym_t'(ch - ChZero + 8'd52);
    else if (ch == ChPlus) s = b64d_pkg::SymPlus;
    else if (ch == ChSlash) s = b64d_pkg::SymSlash;
    else if (ch == ChPad) s = b64d_pkg::SymPad;
    else s = b64d_pkg::SymBad;
    return s;
  endfunction

  function automatic logic [7:0] sym_to_char(input b64d_pkg::sym_t s);
    logic [7:0] ch;
    if (s == b64d_pkg::SymPad) ch = ChPad;
    else if (s < 7'd26) ch = ChUpA + 8'(s);
    else if (s < 7'd52) ch = ChLowA + 8'(s) - 8'd26;
    else if (s < 7'd62) ch = ChZero + 8'(s) - 8'd52;
    else if (s == b64d_pkg::SymPlus) ch = ChPlus;
    else ch = ChSlash;
    return ch;
  endfunction

  // work out the words one accepted input word causes
  task automatic decode_word(input logic [7:0] ch, input logic eot);
    b64d_pkg::sym_t    s;
    b64d_pkg::status_e fin;
    logic [7:0]        dec [3];
    int                nb;
    s = char_to_sym(ch);
    if (eot) begin
      fin = err;
      if (fin == b64d_pkg::StOk && grp_cnt != 0) fin = b64d_pkg::StInvalid;
      decoded_q.push_back('{data: 8'h00, status: fin, last: 1'b1});
      for (int i = 0; i < 3; i++) grp_sym[i] = '0;
      grp_cnt   = 0;
      after_pad = 1'b0;
      err       = b64d_pkg::StOk;
      emitted   = 16'd0;
    end else if (err != b64d_pkg::StOk || is_space(ch)) begin
      // ignored
    end else if (after_pad || s == b64d_pkg::SymBad) begin
      err = b64d_pkg::StInvalid;
    end else if (grp_cnt < 3) begin
      grp_sym[grp_cnt] = s;
      grp_cnt++;
    end else begin
      grp_cnt = 0;
      if (grp_sym[0] == b64d_pkg::SymPad || grp_sym[1] == b64d_pkg::SymPad ||
          (grp_sym[2] == b64d_pkg::SymPad && s != b64d_pkg::SymPad) ||
          (grp_sym[2] == b64d_pkg::SymPad && grp_sym[1][3:0] != 4'd0) ||
          (s == b64d_pkg::SymPad && grp_sym[2] != b64d_pkg::SymPad &&
           grp_sym[2][1:0] != 2'd0)) begin
        err = b64d_pkg::StInvalid;
      end else begin
        dec[0] = {grp_sym[0][5:0], grp_sym[1][5:4]};
        dec[1] = {grp_sym[1][3:0], grp_sym[2][5:2]};
        dec[2] = {grp_sym[2][1:0], s[5:0]};
        nb = (grp_sym[2] == b64d_pkg::SymPad) ? 1 : (s == b64d_pkg::SymPad) ? 2 : 3;
        // bytes that fit go out, the rest of the group is dropped
        for (int i = 0; i < nb && err == b64d_pkg::StOk; i++) begin
          if (emitted >= cap) begin
            err = b64d_pkg::StNoSpace;
          end else begin
            emitted++;
            decoded_q.push_back('{data: dec[i], status: b64d_pkg::StOk, last: 1'b0});
          end
        end
        if (err == b64d_pkg::StOk) after_pad = (s == b64d_pkg::SymPad);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  // input driver and predictor hook
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) decode_word(in_char_i, end_of_text_i);
      if (!in_valid_i || in_ready_o) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_word = word_q.pop_front();
          in_valid_i    <= 1'b1;
          in_char_i     <= drv_word.ch;
          end_of_text_i <= drv_word.eot;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word byte=%h status=%0d last=%b",
                                  out_byte_o, status_o, last_o));
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("byte %h, wanted %h", out_byte_o, want.data));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", status_o, want.status));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", last_o, want.last));
      end
    end
  end

  task automatic push_word(input logic [7:0] ch, input logic eot);
    word_q.push_back('{ch: ch, eot: eot});
    pushed_cnt++;
  endtask

  task automatic push_text(input string txt);
    for (int i = 0; i < txt.len(); i++) push_word(txt[i], 1'b0);
  endtask

  // one symbol, sometimes after a blank, rarely replaced by a random byte
  task automatic push_sym(input b64d_pkg::sym_t s);
    logic [7:0] ch;
    ch = sym_to_char(s);
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(3))
        0: push_word(ChSpace, 1'b0);
        1: push_word(ChTab, 1'b0);
        2: push_word(ChCr, 1'b0);
        default: push_word(ChLf, 1'b0);
      endcase
    end
    if ($urandom_range(99) < 3) ch = 8'($urandom_range(255));
    push_word(ch, 1'b0);
  endtask

  // mostly well-formed element: groups, optional padding, end word
  task automatic queue_element();
    int             ngroups;
    int             tail;
    b64d_pkg::sym_t g [4];
    ngroups = $urandom_range(4);
    for (int k = 0; k < ngroups; k++) begin
      for (int j = 0; j < 4; j++) g[j] = b64d_pkg::sym_t'($urandom_range(63));
      if (k == ngroups - 1) begin
        tail = $urandom_range(2);
        if (tail == 1) begin
          g[2][1:0] = 2'd0;
          g[3] = b64d_pkg::SymPad;
        end else if (tail == 2) begin
          g[1][3:0] = 4'd0;
          g[2] = b64d_pkg::SymPad;
          g[3] = b64d_pkg::SymPad;
        end
      end
      for (int j = 0; j < 4; j++) push_sym(g[j]);
    end
    // broken tail: junk byte or a stray symbol
    case ($urandom_range(9))
      0: push_word(8'($urandom_range(255)), 1'b0);
      1: push_sym(b64d_pkg::sym_t'($urandom_range(63)));
      default: ;
    endcase
    push_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic queue_phase(input int target);
    int start;
    start = pushed_cnt;
    while (pushed_cnt - start < target) queue_element();
  endtask

  // wait until every word is in and every result is out, then let the block settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (word_q.size() != 0 || in_valid_i || decoded_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cap = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    for (int i = 0; i < 3; i++) grp_sym[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full group with a tab, plus and slash, padding, data after padding
    push_text("TW\tFu");
    push_text("+/+/");
    push_text("TQ==");
    push_word(ChLf, 1'b0);
    push_text("A");
    push_word(8'hFF, 1'b1);
    // nonzero leftover bits before padding, then an illegal byte
    push_text("TWF=");
    push_word(8'h00, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'h7F, 1'b1);
    // incomplete group at end
    push_text("TW");
    push_word(8'h00, 1'b1);
    wait_drained();

    // capacity lowered below what this element already wrote
    push_text("TWFu");
    wait_drained();
    write_capacity(16'd2);
    push_text("TWFu");
    push_word(8'h00, 1'b1);
    // capacity runs out mid group
    push_text("TWFu");
    push_word(8'h00, 1'b1);
    wait_drained();
    write_capacity(16'd0);
    push_text("AAAA");
    push_word(8'h00, 1'b1);
    wait_drained();
    write_capacity(16'hFFFF);

    // random: sender idles less than receiver
    queue_phase(PhaseWords);
    wait_drained();

    // random: the other way round, small capacity
    send_idle_pct = 47;
    recv_idle_pct = 18;
    write_capacity(16'($urandom_range(3, 40)));
    queue_phase(PhaseWords);
    wait_drained();

    // random: no idling, long receiver hold-off up front
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(16'($urandom_range(64, 65535)));
    queue_phase(PhaseWords);
    @(posedge clk_i);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("strict_base64_stream_decoder_tb: PASS");
    end else begin
      $display("strict_base64_stream_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
